>>> hdl/paced_serial_byte_queues_macros.svh
// Assertion macros shared by the paced serial byte queue modules.
`ifndef PACED_SERIAL_BYTE_QUEUES_MACROS_SVH
`define PACED_SERIAL_BYTE_QUEUES_MACROS_SVH

// Checked on every rising edge outside of reset.
`define PSBQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PSBQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/psbq_pkg.sv
package psbq_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 32;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  localparam int DLY_W = 13;
  localparam int TICK_W = 16;
  localparam int MIN_US = 10;
  localparam int TICKS_PER_4US = 59;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PACING_DELAY = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_RX_BYTE = 3'd1,
    CMD_ENQUEUE = 3'd2,
    CMD_READ = 3'd3,
    CMD_TX_DONE = 3'd4
  } psbq_cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [2:0] rx_error_bits;
  } psbq_in_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_data;
    logic       send_valid;
    logic [7:0] send_data;
    logic       enqueue_dropped;
    logic [5:0] tx_level;
  } psbq_out_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_ticks;
    logic [TICK_W-1:0] pacing_ticks;
  } psbq_delay_t;

  typedef struct packed {
    logic             send_valid;
    logic             enqueue_dropped;
    logic [TX_CW-1:0] level;
  } psbq_tx_stat_t;

endpackage

>>> hdl/psbq_ram.sv
module psbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/psbq_cfg.sv
module psbq_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psbq_pkg::DLY_W-1:0]     cfg_data_i,
  output psbq_pkg::psbq_delay_t          delay_o
);
  import psbq_pkg::*;

  function automatic logic [TICK_W-1:0] us_to_ticks(input logic [DLY_W-1:0] us);
    logic [DLY_W-1:0] clipped;
    logic [DLY_W+3:0] prod;
    clipped = (us < DLY_W'(MIN_US)) ? DLY_W'(MIN_US) : us;
    prod = (DLY_W+4)'(clipped[DLY_W-1:2]) * (DLY_W+4)'(TICKS_PER_4US);
    return (|prod[DLY_W+3:TICK_W]) ? '1 : prod[TICK_W-1:0];
  endfunction

  psbq_delay_t delay_q, delay_d;

  always_comb begin
    delay_d = delay_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_DELAY: delay_d.start_ticks = us_to_ticks(cfg_data_i);
        REG_PACING_DELAY: delay_d.pacing_ticks = us_to_ticks(cfg_data_i);
        default: delay_d = delay_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q.start_ticks <= us_to_ticks(DLY_W'(MIN_US));
      delay_q.pacing_ticks <= us_to_ticks(DLY_W'(MIN_US));
    end else begin
      delay_q <= delay_d;
    end
  end

  assign delay_o = delay_q;

endmodule

>>> hdl/psbq_rx.sv
`include "paced_serial_byte_queues_macros.svh"

module psbq_rx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  psbq_pkg::psbq_in_t  in_i,
  output logic                read_valid_o,
  output logic [7:0]          read_data_o
);
  import psbq_pkg::*;

  logic [RX_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic             rd_valid_q, rd_valid_d;
  logic             wr_en;
  logic [7:0]       rdata;

  function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] i);
    return (i == RX_AW'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    wr_en = 1'b0;
    rd_valid_d = 1'b0;
    if (accept_i) begin
      if (in_i.command == CMD_RX_BYTE && in_i.rx_error_bits == '0) begin
        wr_en = 1'b1;
        head_d = rx_next(head_q);
      end
      if (in_i.command == CMD_READ && tail_q != head_q) begin
        rd_valid_d = 1'b1;
        tail_d = rx_next(tail_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  psbq_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(head_q),
    .wdata_i(in_i.data_byte),
    .raddr_i(tail_q),
    .rdata_o(rdata)
  );

  assign read_valid_o = rd_valid_q;
  assign read_data_o = rd_valid_q ? rdata : 8'd0;

  `PSBQ_ASSERT(a_read_not_empty, rd_valid_q |-> $past(tail_q) != $past(head_q), "Read from empty ring.")
  `PSBQ_ASSERT(a_tail_moves_on_read, (tail_q != $past(tail_q)) |-> rd_valid_q, "Tail moved without read.")

endmodule

>>> hdl/psbq_tx.sv
`include "paced_serial_byte_queues_macros.svh"

module psbq_tx (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  psbq_pkg::psbq_in_t     in_i,
  input  psbq_pkg::psbq_delay_t  delay_i,
  output psbq_pkg::psbq_tx_stat_t stat_o,
  output logic [7:0]             send_data_o
);
  import psbq_pkg::*;

  localparam int SUM_W = TX_AW + 1;

  logic [TX_AW-1:0]  tail_q, tail_d;
  logic [TX_CW-1:0]  count_q, count_d;
  logic              burst_q, burst_d;
  logic              armed_q, armed_d;
  logic [TICK_W-1:0] gap_q, gap_d;
  logic              snd_q, snd_d;
  logic              drop_q, drop_d;
  logic              wr_en;
  logic [SUM_W-1:0]  slot_sum;
  logic [TX_AW-1:0]  slot;
  logic [7:0]        rdata;

  always_comb begin
    slot_sum = SUM_W'(tail_q) + SUM_W'(count_q);
    if (slot_sum >= SUM_W'(TX_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(TX_DEPTH);
    end
    slot = slot_sum[TX_AW-1:0];
  end

  always_comb begin
    tail_d = tail_q;
    count_d = count_q;
    burst_d = burst_q;
    armed_d = armed_q;
    gap_d = gap_q;
    snd_d = 1'b0;
    drop_d = 1'b0;
    wr_en = 1'b0;
    if (accept_i) begin
      case (in_i.command)
        CMD_TICK: begin
          if (armed_q) begin
            if (gap_q > TICK_W'(1)) begin
              gap_d = gap_q - 1'b1;
            end else begin
              gap_d = '0;
              armed_d = 1'b0;
              if (count_q != '0) begin
                snd_d = 1'b1;
                tail_d = (tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                count_d = count_q - 1'b1;
              end
            end
          end
        end
        CMD_ENQUEUE: begin
          if (count_q >= TX_CW'(TX_DEPTH)) begin
            drop_d = 1'b1;
          end else begin
            wr_en = 1'b1;
            count_d = count_q + 1'b1;
            if (!burst_q) begin
              burst_d = 1'b1;
              armed_d = 1'b1;
              gap_d = delay_i.start_ticks;
            end
          end
        end
        CMD_TX_DONE: begin
          if (burst_q) begin
            if (count_q == '0) begin
              burst_d = 1'b0;
            end else begin
              armed_d = 1'b1;
              gap_d = delay_i.pacing_ticks;
            end
          end
        end
        default: begin
          tail_d = tail_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
      count_q <= '0;
      burst_q <= 1'b0;
      armed_q <= 1'b0;
      gap_q <= '0;
      snd_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      tail_q <= tail_d;
      count_q <= count_d;
      burst_q <= burst_d;
      armed_q <= armed_d;
      gap_q <= gap_d;
      snd_q <= snd_d;
      drop_q <= drop_d;
    end
  end

  psbq_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(slot),
    .wdata_i(in_i.data_byte),
    .raddr_i(tail_q),
    .rdata_o(rdata)
  );

  assign stat_o.send_valid = snd_q;
  assign stat_o.enqueue_dropped = drop_q;
  assign stat_o.level = count_q;
  assign send_data_o = snd_q ? rdata : 8'd0;

  `PSBQ_ASSERT_ALWAYS(a_count_bound, count_q <= TX_CW'(TX_DEPTH), "Transmit count overflow.")
  `PSBQ_ASSERT(a_armed_in_burst, armed_q |-> (burst_q && count_q != '0), "Armed outside a burst.")
  `PSBQ_ASSERT(a_send_had_byte, snd_q |-> $past(count_q) != '0, "Sent from empty queue.")

endmodule

>>> hdl/paced_serial_byte_queues.sv
// The result word is strobed in the cycle after the command is accepted.
// Throughput: one command per cycle; busy_o stays low, since each command makes a
// single access to the receive or transmit memory, each with a registered read.
// Reset clears the queue pointers, counts and delay timer, and sets both delays
// to 10 us; memory contents are undefined until written. The receiver cannot stall.
module paced_serial_byte_queues (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  psbq_pkg::psbq_in_t             in_i,
  output logic                           done_o,
  output psbq_pkg::psbq_out_t            res_o,
  input  logic                           cfg_we_i,
  input  logic [psbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psbq_pkg::DLY_W-1:0]     cfg_data_i
);
  import psbq_pkg::*;

  logic          accept;
  logic          done_q;
  psbq_delay_t   delay;
  psbq_tx_stat_t tx_stat;
  logic          rd_valid;
  logic [7:0]    rd_data;
  logic [7:0]    snd_data;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  psbq_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .delay_o   (delay)
  );

  psbq_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .read_valid_o(rd_valid),
    .read_data_o (rd_data)
  );

  psbq_tx u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .delay_i    (delay),
    .stat_o     (tx_stat),
    .send_data_o(snd_data)
  );

  assign done_o = done_q;
  assign res_o.read_valid = rd_valid;
  assign res_o.read_data = rd_data;
  assign res_o.send_valid = tx_stat.send_valid;
  assign res_o.send_data = snd_data;
  assign res_o.enqueue_dropped = tx_stat.enqueue_dropped;
  assign res_o.tx_level = 6'(tx_stat.level);

endmodule

>>> dv/psbq_checker.sv
`timescale 1ns / 100ps

module psbq_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_o,
  input  psbq_pkg::psbq_in_t             in_i,
  input  logic                           done_o,
  input  psbq_pkg::psbq_out_t            res_o,
  input  logic                           cfg_we_i,
  input  logic [psbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psbq_pkg::DLY_W-1:0]     cfg_data_i,
  input  logic                           drain_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    sent_o,
  output int unsigned                    refused_o,
  output int unsigned                    read_back_o
);
  import psbq_pkg::*;

  logic [7:0]        rx_mem [RX_DEPTH];
  logic [RX_AW-1:0]  rx_wr;
  logic [RX_AW-1:0]  rx_rd;
  logic [7:0]        tx_mem [TX_DEPTH];
  logic [TX_AW-1:0]  tx_rd;
  logic [TX_CW-1:0]  tx_fill;
  logic              in_burst;
  logic              counting;
  logic [TICK_W-1:0] ticks_left;
  logic [DLY_W-1:0]  start_us;
  logic [DLY_W-1:0]  pacing_us;
  psbq_out_t         awaited_res [$];
  int unsigned       result_no;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    sent_o = 0;
    refused_o = 0;
    read_back_o = 0;
    result_no = 0;
  end

  task automatic flag(input string msg);
    if (fail_count_o < 40) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      flag($sformatf("result word %0d: %s is %0h, expected %0h", result_no, name, got, want));
    end
  endtask

  function automatic logic [TICK_W-1:0] delay_ticks(input logic [DLY_W-1:0] us);
    int unsigned u;
    int unsigned t;
    u = us;
    if (u < MIN_US) u = MIN_US;
    t = (u >> 2) * TICKS_PER_4US;
    if (t > 32'hFFFF) return '1;
    return TICK_W'(t);
  endfunction

  function automatic psbq_out_t step_queues(input psbq_in_t w);
    psbq_out_t        r;
    logic [TX_AW-1:0] slot;
    r = '0;
    case (w.command)
      CMD_TICK: begin
        if (counting) begin
          if (ticks_left > 1) begin
            ticks_left--;
          end else begin
            ticks_left = '0;
            counting = 1'b0;
            if (tx_fill != 0) begin
              r.send_valid = 1'b1;
              r.send_data = tx_mem[tx_rd];
              tx_rd++;
              tx_fill--;
            end
          end
        end
      end
      CMD_RX_BYTE: begin
        if (w.rx_error_bits == '0) begin
          rx_mem[rx_wr] = w.data_byte;
          rx_wr++;
        end
      end
      CMD_ENQUEUE: begin
        if (tx_fill >= TX_DEPTH) begin
          r.enqueue_dropped = 1'b1;
        end else begin
          slot = tx_rd + tx_fill[TX_AW-1:0];
          tx_mem[slot] = w.data_byte;
          tx_fill++;
          if (!in_burst) begin
            in_burst = 1'b1;
            counting = 1'b1;
            ticks_left = delay_ticks(start_us);
          end
        end
      end
      CMD_READ: begin
        if (rx_rd != rx_wr) begin
          r.read_valid = 1'b1;
          r.read_data = rx_mem[rx_rd];
          rx_rd++;
        end
      end
      CMD_TX_DONE: begin
        if (in_burst) begin
          if (tx_fill == 0) begin
            in_burst = 1'b0;
          end else begin
            counting = 1'b1;
            ticks_left = delay_ticks(pacing_us);
          end
        end
      end
      default: ;
    endcase
    r.tx_level = 6'(tx_fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    psbq_out_t want;
    if (!rst_ni) begin
      rx_wr = '0;
      rx_rd = '0;
      tx_rd = '0;
      tx_fill = '0;
      in_burst = 1'b0;
      counting = 1'b0;
      ticks_left = '0;
      start_us = DLY_W'(MIN_US);
      pacing_us = DLY_W'(MIN_US);
      awaited_res.delete();
    end else begin
      if (done_o) begin
        result_no++;
        if (awaited_res.size() == 0) begin
          flag($sformatf("result word %0d arrived with none expected", result_no));
        end else begin
          want = awaited_res.pop_front();
          check_field("read_valid", 8'(res_o.read_valid), 8'(want.read_valid));
          check_field("read_data", res_o.read_data, want.read_data);
          check_field("send_valid", 8'(res_o.send_valid), 8'(want.send_valid));
          check_field("send_data", res_o.send_data, want.send_data);
          check_field("enqueue_dropped", 8'(res_o.enqueue_dropped), 8'(want.enqueue_dropped));
          check_field("tx_level", 8'(res_o.tx_level), 8'(want.tx_level));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_DELAY:  start_us = cfg_data_i;
          REG_PACING_DELAY: pacing_us = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        want = step_queues(in_i);
        awaited_res.push_back(want);
        if (want.send_valid) sent_o++;
        if (want.enqueue_dropped) refused_o++;
        if (want.read_valid) read_back_o++;
      end
      if (drain_i && awaited_res.size() != 0) begin
        flag($sformatf("%0d expected result words never arrived", awaited_res.size()));
        awaited_res.delete();
      end
    end
    pending_o = awaited_res.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import psbq_pkg::*;

  localparam logic [2:0] CMD_SPARE = 3'(CMD_TX_DONE) + 3'd1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  psbq_in_t             in_i;
  logic                 done_o;
  psbq_out_t            res_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DLY_W-1:0]     cfg_data_i;
  logic                 drain;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          sent;
  int unsigned          refused;
  int unsigned          read_back;

  int unsigned idle_pct;
  int unsigned total_words;
  int unsigned tick_words;
  int unsigned phase_words;
  int unsigned phase_quota;
  int unsigned start_tab [4] = '{0, 13, 8191, 4443};
  int unsigned pacing_tab [4] = '{15, 0, 11, 4443};
  int unsigned idle_tab [4] = '{0, 62, 15, 0};
  int unsigned quota_tab [4] = '{300, 250, 200, 150};

  paced_serial_byte_queues i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  psbq_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .in_i         (in_i),
    .done_o       (done_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .drain_i      (drain),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .sent_o       (sent),
    .refused_o    (refused),
    .read_back_o  (read_back)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic psbq_in_t word_of(input logic [2:0] cmd, input logic [7:0] data,
                                       input logic [2:0] errs);
    psbq_in_t w;
    w.command = cmd;
    w.data_byte = data;
    w.rx_error_bits = errs;
    return w;
  endfunction

  task automatic drive_word(input psbq_in_t w);
    if (phase_words >= phase_quota) return;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy_o);
    total_words++;
    phase_words++;
    if (w.command == CMD_TICK) tick_words++;
  endtask

  task automatic tick_run(input int unsigned len);
    int unsigned r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        drive_word(word_of(CMD_TICK, 8'($urandom), 3'($urandom)));
      end else if (r < 90) begin
        drive_word(word_of(CMD_RX_BYTE, 8'($urandom), 3'b000));
      end else if (r < 93) begin
        drive_word(word_of(CMD_RX_BYTE, 8'($urandom), 3'($urandom_range(1, 7))));
      end else if (r < 97) begin
        drive_word(word_of(CMD_READ, 8'($urandom), 3'($urandom)));
      end else if (r < 98) begin
        drive_word(word_of(CMD_SPARE + 3'($urandom_range(0, 2)), 8'($urandom), 3'($urandom)));
      end else if (r < 99) begin
        drive_word(word_of(CMD_ENQUEUE, 8'($urandom), 3'($urandom)));
      end else begin
        drive_word(word_of(CMD_TX_DONE, 8'($urandom), 3'($urandom)));
      end
    end
  endtask

  task automatic set_delays(input logic [DLY_W-1:0] start_us, input logic [DLY_W-1:0] pacing_us);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_START_DELAY;
    cfg_data_i <= start_us;
    @(negedge clk_i);
    cfg_idx_i <= REG_PACING_DELAY;
    cfg_data_i <= pacing_us;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_sequence();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      n = $urandom_range(1, 4);
      repeat (n) drive_word(word_of(CMD_ENQUEUE, 8'($urandom), 3'($urandom)));
      repeat (n + 1) begin
        tick_run($urandom_range(90, 200));
        drive_word(word_of(CMD_TX_DONE, 8'($urandom), 3'($urandom)));
      end
    end else if (kind < 60) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 9) < 6) begin
          drive_word(word_of(CMD_RX_BYTE, 8'($urandom),
                             ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b000));
        end else begin
          drive_word(word_of(CMD_READ, 8'($urandom), 3'($urandom)));
        end
      end
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 20)) drive_word(word_of(CMD_READ, 8'($urandom), 3'($urandom)));
    end else if (kind < 75) begin
      repeat ($urandom_range(120, 140)) drive_word(word_of(CMD_RX_BYTE, 8'($urandom), 3'b000));
    end else if (kind < 80) begin
      repeat ($urandom_range(30, 36)) drive_word(word_of(CMD_ENQUEUE, 8'($urandom), 3'($urandom)));
      repeat ($urandom_range(2, 5)) begin
        tick_run($urandom_range(90, 200));
        drive_word(word_of(CMD_TX_DONE, 8'($urandom), 3'($urandom)));
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        drive_word(word_of(3'($urandom_range(0, 7)), 8'($urandom), 3'($urandom)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    drain = 1'b0;
    idle_pct = 0;
    total_words = 0;
    tick_words = 0;
    phase_words = 0;
    phase_quota = '1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    drive_word(word_of(CMD_READ, 8'h00, 3'b000));
    drive_word(word_of(CMD_RX_BYTE, 8'hA5, 3'b100));
    drive_word(word_of(CMD_RX_BYTE, 8'h5A, 3'b010));
    drive_word(word_of(CMD_RX_BYTE, 8'hC3, 3'b001));
    drive_word(word_of(CMD_RX_BYTE, 8'h00, 3'b111));
    drive_word(word_of(CMD_RX_BYTE, 8'h00, 3'b000));
    drive_word(word_of(CMD_RX_BYTE, 8'hFF, 3'b000));
    drive_word(word_of(CMD_READ, 8'hFF, 3'b111));
    drive_word(word_of(CMD_READ, 8'h00, 3'b000));
    drive_word(word_of(CMD_READ, 8'h00, 3'b000));
    drive_word(word_of(CMD_SPARE, 8'hFF, 3'b111));
    drive_word(word_of(CMD_SPARE + 3'd1, 8'h00, 3'b000));
    drive_word(word_of(CMD_SPARE + 3'd2, 8'hFF, 3'b111));
    drive_word(word_of(CMD_TX_DONE, 8'h00, 3'b000));
    drive_word(word_of(CMD_TICK, 8'h00, 3'b000));
    drive_word(word_of(CMD_ENQUEUE, 8'hFF, 3'b000));
    drive_word(word_of(CMD_ENQUEUE, 8'h00, 3'b111));
    drive_word(word_of(CMD_TX_DONE, 8'hFF, 3'b111));
    drive_word(word_of(CMD_TICK, 8'hFF, 3'b111));

    for (int p = 0; p < 4; p++) begin
      set_delays(DLY_W'(start_tab[p]), DLY_W'(pacing_tab[p]));
      idle_pct = idle_tab[p];
      phase_words = 0;
      phase_quota = quota_tab[p];
      while (phase_words < phase_quota) run_sequence();
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    for (int i = 0; i < 200 && pending != 0; i++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    drain <= 1'b1;
    repeat (2) @(negedge clk_i);

    $display("Drove %0d command words, %0d of them timer ticks, over four delay settings",
             total_words, tick_words);
    $display("and three sender idle rates; %0d bytes sent, %0d enqueues refused, %0d read back.",
             sent, refused, read_back);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
